FILE: src/lcdb_pkg.sv
`timescale 1ns / 1ps

package lcdb_pkg;

    // operation codes of an input word
    typedef enum logic [2:0] {
        OP_INIT          = 3'd0,
        OP_COMMAND       = 3'd1,
        OP_DATA          = 3'd2,
        OP_SET_CURSOR    = 3'd3,
        OP_BACKLIGHT_ON  = 3'd4,
        OP_BACKLIGHT_OFF = 3'd5
    } op_t;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_COLUMNS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_ROWS    = 2'd2;

    localparam logic [7:0] BAD_ADDR   = 8'hFF;
    localparam logic [7:0] CURSOR_CMD = 8'h80;
    localparam logic [7:0] MAX_ROWS   = 8'd4;

    // init sequence: twelve nibbles, index of the final one
    localparam logic [3:0] INIT_LAST_NIB = 4'd11;
    // a byte job sends its high then its low nibble
    localparam logic [3:0] BYTE_LAST_NIB = 4'd1;

    localparam int unsigned LCDB_QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        JOB_INIT   = 2'd0,
        JOB_BYTE   = 2'd1,
        JOB_SINGLE = 2'd2
    } job_kind_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] byte_value;
        logic [7:0] cursor_column;
        logic [7:0] cursor_row;
    } in_word_t;

    typedef struct packed {
        logic [7:0] expander_byte;
        logic [7:0] target_address;
        logic       last;
    } out_word_t;

    // one classified operation waiting for the back end
    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] value;
        logic       rs;
        logic       backlight;
        logic [7:0] address;
    } job_t;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        case (row)
            2'd0:    base = 8'h00;
            2'd1:    base = 8'h40;
            2'd2:    base = 8'h14;
            2'd3:    base = 8'h54;
            default: base = 8'h00;
        endcase
        return base;
    endfunction

    // wake-up nibbles 3,3,3,2 then commands 0x28, 0x0c, 0x01, 0x06
    function automatic logic [3:0] init_nibble(input logic [3:0] idx);
        logic [3:0] nib;
        case (idx)
            4'd0, 4'd1, 4'd2: nib = 4'h3;
            4'd3:             nib = 4'h2;
            4'd4:             nib = 4'h2;
            4'd5:             nib = 4'h8;
            4'd6:             nib = 4'h0;
            4'd7:             nib = 4'hC;
            4'd8:             nib = 4'h0;
            4'd9:             nib = 4'h1;
            4'd10:            nib = 4'h0;
            4'd11:            nib = 4'h6;
            default:          nib = 4'h0;
        endcase
        return nib;
    endfunction

endpackage

FILE: src/char_lcd_i2c_backpack_sequencer_core.sv
`timescale 1ns / 1ps

// character lcd sequencer for a 4-bit display behind an 8-bit i2c port expander
// in channel (in_valid/in_ready/in_data): one lcd operation per word
// out channel (out_valid/out_ready/out_data): one expander byte per word, with
//   the i2c address it goes to and a last flag on the final byte of an operation
// cfg port: cfg_write with cfg_index 0 address, 1 columns, 2 rows, no wait
// throughput: a command, data or set cursor word gives 6 bytes on the out
//   channel, a backlight word 1 byte, init 36 bytes; the back end emits one
//   byte per cycle unless the receiver stalls, so its byte counter sets the rate
// an accepted word enters the job queue, then its first byte is registered out
// words that emit nothing (ops before a good init, failed init, unused codes,
//   cursor rows past the fourth) are taken without a queue entry and only touch state
// the job queue lets the input accept further words while the back end
//   streams; when the receiver stalls the output register holds and the queue
//   fills, then in_ready drops
// reset: not initialized, backlight on, address 255, sizes zero, queue empty

module char_lcd_i2c_backpack_sequencer_core import lcdb_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = LCDB_QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_word_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_word_t              out_data
);

    // front to queue
    logic job_push;
    job_t job;
    logic queue_full;

    // queue to back end
    logic head_valid;
    job_t head;
    logic pop;

    // front: config registers, lcd state, classification of each word
    lcdb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .queue_full (queue_full),
        .job_push   (job_push),
        .job        (job)
    );

    // short job queue decoupling accept from byte streaming
    lcdb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // back end: expands the head job into expander bytes, one per cycle unless stalled
    lcdb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

FILE: src/lcdb_front.sv
`timescale 1ns / 1ps

module lcdb_front import lcdb_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_word_t               in_data,
    input  logic                   queue_full,
    output logic                   job_push,
    output job_t                   job
);

    logic [7:0] cfg_addr_reg;
    logic [7:0] cfg_cols_reg;
    logic [7:0] cfg_rows_reg;

    logic       ready_flag_reg,  ready_flag_next;
    logic       backlight_reg,   backlight_next;
    logic [7:0] lat_addr_reg,    lat_addr_next;
    logic [7:0] lat_cols_reg,    lat_cols_next;
    logic [7:0] lat_rows_reg,    lat_rows_next;

    logic       accept;
    logic       ok;
    logic       emits;
    logic [7:0] row_clamped;
    logic [7:0] col_clamped;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign ok       = ready_flag_reg && (lat_addr_reg != BAD_ADDR);
    assign job_push = accept && emits;

    assign row_clamped = (in_data.cursor_row >= lat_rows_reg) ?
                         8'(lat_rows_reg - 8'd1) : in_data.cursor_row;
    assign col_clamped = (in_data.cursor_column >= lat_cols_reg) ?
                         8'(lat_cols_reg - 8'd1) : in_data.cursor_column;

    always_comb
    begin
        ready_flag_next = ready_flag_reg;
        backlight_next  = backlight_reg;
        lat_addr_next   = lat_addr_reg;
        lat_cols_next   = lat_cols_reg;
        lat_rows_next   = lat_rows_reg;
        emits           = 1'b0;
        job.kind        = JOB_BYTE;
        job.value       = in_data.byte_value;
        job.rs          = 1'b0;
        job.backlight   = backlight_reg;
        job.address     = lat_addr_reg;
        case (in_data.operation)
            OP_INIT:
            begin
                ready_flag_next = 1'b0;
                if (cfg_addr_reg != BAD_ADDR && cfg_cols_reg != 8'd0 &&
                    cfg_rows_reg != 8'd0)
                begin
                    ready_flag_next = 1'b1;
                    backlight_next  = 1'b1;
                    lat_addr_next   = cfg_addr_reg;
                    lat_cols_next   = cfg_cols_reg;
                    lat_rows_next   = cfg_rows_reg;
                    emits           = 1'b1;
                    job.kind        = JOB_INIT;
                    job.value       = 8'h00;
                    job.backlight   = 1'b1;
                    job.address     = cfg_addr_reg;
                end
            end
            OP_COMMAND:
            begin
                emits = ok;
            end
            OP_DATA:
            begin
                emits  = ok;
                job.rs = 1'b1;
            end
            OP_SET_CURSOR:
            begin
                emits     = ok && (row_clamped < MAX_ROWS);
                job.value = CURSOR_CMD | 8'(row_base(row_clamped[1:0]) + col_clamped);
            end
            OP_BACKLIGHT_ON:
            begin
                if (ok)
                begin
                    backlight_next = 1'b1;
                end
                emits         = ok;
                job.kind      = JOB_SINGLE;
                job.value     = 8'h00;
                job.backlight = 1'b1;
            end
            OP_BACKLIGHT_OFF:
            begin
                if (ok)
                begin
                    backlight_next = 1'b0;
                end
                emits         = ok;
                job.kind      = JOB_SINGLE;
                job.value     = 8'h00;
                job.backlight = 1'b0;
            end
            default:
            begin
                emits = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_addr_reg   <= BAD_ADDR;
            cfg_cols_reg   <= 8'd0;
            cfg_rows_reg   <= 8'd0;
            ready_flag_reg <= 1'b0;
            backlight_reg  <= 1'b1;
            lat_addr_reg   <= BAD_ADDR;
            lat_cols_reg   <= 8'd0;
            lat_rows_reg   <= 8'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_DEVICE_ADDRESS:  cfg_addr_reg <= cfg_data;
                    CFG_DISPLAY_COLUMNS: cfg_cols_reg <= cfg_data;
                    CFG_DISPLAY_ROWS:    cfg_rows_reg <= cfg_data;
                    default:             ;
                endcase
            end
            if (accept)
            begin
                ready_flag_reg <= ready_flag_next;
                backlight_reg  <= backlight_next;
                lat_addr_reg   <= lat_addr_next;
                lat_cols_reg   <= lat_cols_next;
                lat_rows_reg   <= lat_rows_next;
            end
        end
    end

endmodule

FILE: src/lcdb_queue.sv
`timescale 1ns / 1ps

module lcdb_queue import lcdb_pkg::*; #(
    parameter int unsigned DEPTH = LCDB_QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: src/lcdb_back.sv
`timescale 1ns / 1ps

module lcdb_back import lcdb_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  job_t      head,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    // three bytes per nibble: setup, enable strobe, hold
    localparam logic [1:0] PHASE_SETUP  = 2'd0;
    localparam logic [1:0] PHASE_STROBE = 2'd1;
    localparam logic [1:0] PHASE_HOLD   = 2'd2;

    logic [3:0] nib_cnt_reg, nib_cnt_next;
    logic [1:0] phase_reg,   phase_next;
    logic       out_valid_reg, out_valid_next;
    out_word_t  out_data_reg;

    logic       advance;
    logic       job_end;
    logic [3:0] nibble;
    logic       enable;
    out_word_t  word_c;

    assign advance = head_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        case (head.kind)
            JOB_INIT:   job_end = (nib_cnt_reg == INIT_LAST_NIB) && (phase_reg == PHASE_HOLD);
            JOB_BYTE:   job_end = (nib_cnt_reg == BYTE_LAST_NIB) && (phase_reg == PHASE_HOLD);
            JOB_SINGLE: job_end = 1'b1;
            default:    job_end = 1'b1;
        endcase
    end

    always_comb
    begin
        if (head.kind == JOB_INIT)
        begin
            nibble = init_nibble(nib_cnt_reg);
        end
        else
        begin
            nibble = nib_cnt_reg[0] ? head.value[3:0] : head.value[7:4];
        end
        enable = (phase_reg == PHASE_STROBE) && (head.kind != JOB_SINGLE);
        word_c.expander_byte  = {nibble, head.backlight, enable, 1'b0, head.rs};
        word_c.target_address = head.address;
        word_c.last           = job_end;
    end

    assign pop = advance && job_end;

    always_comb
    begin
        nib_cnt_next   = nib_cnt_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (job_end)
            begin
                nib_cnt_next = 4'd0;
                phase_next   = PHASE_SETUP;
            end
            else if (phase_reg == PHASE_HOLD)
            begin
                nib_cnt_next = 4'(nib_cnt_reg + 4'd1);
                phase_next   = PHASE_SETUP;
            end
            else
            begin
                phase_next = 2'(phase_reg + 2'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nib_cnt_reg   <= 4'd0;
            phase_reg     <= PHASE_SETUP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            nib_cnt_reg   <= nib_cnt_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= word_c;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: src/lcdb_checker.sv
`timescale 1ns / 1ps

module lcdb_checker import lcdb_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);

    // stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

    // enable strobe is always followed at once by the same byte with enable low
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.expander_byte[2] |=>
        out_valid &&
        (out_data.expander_byte == ($past(out_data.expander_byte) & 8'hFB)) &&
        (out_data.target_address == $past(out_data.target_address)))
    else $error("enable strobe not followed by hold byte");

    // bytes of one operation come without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last |=> out_valid)
    else $error("gap inside an operation");

    // nothing is shown right after reset
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
    else $error("output valid out of reset");

endmodule

bind char_lcd_i2c_backpack_sequencer_core lcdb_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
